// File: sv/sfra_pkg.sv
`default_nettype none
package sfra_pkg;

  localparam int unsigned MAX_FREE_RANGES_DEF = 64;
  localparam int unsigned GUARD_BYTES_DEF     = 4096;

  localparam logic [31:0] SPACE_BASE_RST = 32'h0010_0000;
  localparam logic [31:0] SPACE_SIZE_RST = 32'h4000_0000;

  typedef enum logic [1:0] {
    ACT_ANYWHERE = 2'd0,
    ACT_SPECIFIC = 2'd1,
    ACT_FREE     = 2'd2,
    ACT_REINIT   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_FULL    = 3'd3,
    ST_BADFREE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_CARVE,
    S_SHUP,
    S_SHDN,
    S_DONE
  } state_t;

  typedef enum logic [0:0] {
    REG_SPACE_BASE = 1'b0,
    REG_SPACE_SIZE = 1'b1
  } reg_idx_t;

  // highest set bit of a word, one when the word is zero
  function automatic logic [31:0] top_bit(input logic [31:0] a);
    logic [31:0] s;
    s = a;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    if (a == 32'd0) begin
      return 32'd1;
    end
    return s ^ (s >> 1);
  endfunction

endpackage
`default_nettype wire

// File: sv/sorted_free_range_allocator.sv
// sorted free-range allocator: first-fit allocation with coalescing on free
// input channel s_*: one request per beat (allocate anywhere, allocate
//   specific, free, reinit); output channel m_*: one result per request
//   with base, size and status
// the free table lives in one synchronous ram of {size, base} words; the
//   fill count sits in a register
// a request is taken only while the control is idle; the result register
//   lets the next request in while the previous result still waits
// zero-size, bad free and reinit go from idle straight to the done state; a
//   search reads the table entries in order through the ram read port, and
//   an insert or a removal then shifts the entries above the spot; all table
//   reads go through the single ram read port
// reset: in the init state after reset, entry zero is written with the reset space
//   (no request taken meanwhile); the config registers return to defaults
// when the receiver stalls, the finished result waits in the control until
//   the output register frees up; the config port is always ready
`default_nettype none
module sorted_free_range_allocator
  import sfra_pkg::*;
#(
  parameter int unsigned MAX_FREE_RANGES = MAX_FREE_RANGES_DEF,
  parameter int unsigned GUARD_BYTES     = GUARD_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // action[1:0], req_base[33:2], req_size[65:34], req_alignment[97:66]
  input  wire logic [103:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_base[31:0], out_size[63:32], status[66:64]
  output logic [71:0]       m_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned AW = $clog2(MAX_FREE_RANGES);
  localparam int unsigned CW = $clog2(MAX_FREE_RANGES + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_FREE_RANGES);
  localparam logic [33:0] GUARD34  = 34'(GUARD_BYTES);
  localparam logic [33:0] GUARD2   = 34'(2 * GUARD_BYTES);
  localparam logic [32:0] TOP33    = 33'h1_0000_0000;

  // config registers
  logic [31:0] space_base, space_size;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (reg_idx_t'(paddr[2]) == REG_SPACE_SIZE) ? space_size : space_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      space_base <= SPACE_BASE_RST;
      space_size <= SPACE_SIZE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_SPACE_BASE: space_base <= pwdata;
        REG_SPACE_SIZE: space_size <= pwdata;
        default: ;
      endcase
    end
  end

  // free table ram, {size, base}
  logic [63:0] mem [MAX_FREE_RANGES];
  logic [63:0] rdata;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  state_t state, state_next;

  // request registers
  action_t     act;
  logic [31:0] rbase, rsize, ralign;
  logic [33:0] need;
  logic [32:0] rhi;
  logic [CW-1:0] count;

  // search
  logic [CW-1:0] scan_ptr;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  logic          hit, nxt_hit, p_hit;
  logic [AW-1:0] hit_idx, p_idx;
  logic [31:0]   hit_base, hit_size, nxt_base, nxt_size, p_base, p_size;

  // carve and shifting
  logic [33:0]   lo;
  logic [AW-1:0] sh_src, sh_dst, ins_pos;
  logic [CW-1:0] sh_n;
  logic          sh_vld;
  logic [31:0]   ins_base, ins_size;

  // result
  logic [31:0] res_base, res_size;
  status_t     res_status;

  // incoming request fields
  logic          acc;
  action_t       in_act;
  logic [31:0]   in_base, in_size;
  logic [32:0]   in_hi, sp_end, ri_sz;
  logic          in_bad;

  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign in_act   = action_t'(s_tdata[1:0]);
  assign in_base  = s_tdata[33:2];
  assign in_size  = s_tdata[65:34];
  assign in_hi    = {1'b0, in_base} + {1'b0, in_size};
  assign sp_end   = {1'b0, space_base} + {1'b0, space_size};
  assign in_bad   = (in_hi > TOP33) || (in_base < space_base) || (in_hi > sp_end);
  // reinit clips the space at the top of the address range
  assign ri_sz    = (sp_end > TOP33) ? (TOP33 - {1'b0, space_base}) : {1'b0, space_size};

  // entry under test during the search
  logic [31:0] e_base, e_size;
  logic [32:0] e_end, e_sum;
  logic        m_any, m_spec, m_pred, m_p, issue;

  assign e_base = rdata[31:0];
  assign e_size = rdata[63:32];
  assign e_end  = {1'b0, e_base} + {1'b0, e_size};
  assign e_sum  = {1'b0, e_size} + {1'b0, rsize};
  assign m_any  = {2'b00, e_size} >= need;
  assign m_spec = (rbase >= e_base) && (rhi <= e_end);
  assign m_pred = (e_end == {1'b0, rbase}) && !e_sum[32];
  assign m_p    = {1'b0, e_base} >= rhi;
  assign issue  = scan_ptr < count;

  // free decisions
  logic [32:0] f_sum1, f_sum2, p_sum;
  logic        f_join, p_join, full;

  assign f_sum1 = {1'b0, hit_size} + {1'b0, rsize};
  assign f_sum2 = {1'b0, f_sum1[31:0]} + {1'b0, nxt_size};
  assign f_join = nxt_hit && ({1'b0, nxt_base} == rhi) && !f_sum2[32];
  assign p_sum  = {1'b0, p_size} + {1'b0, rsize};
  assign p_join = p_hit && ({1'b0, p_base} == rhi) && !p_sum[32];
  assign full   = (count >= MAXC);

  // carve decisions
  logic [33:0] eb, ee, chi, a_lo;
  logic        c_left, c_right;

  assign eb      = {2'b00, hit_base};
  assign ee      = {2'b00, hit_base} + {2'b00, hit_size};
  assign chi     = lo + {2'b00, rsize};
  assign c_left  = lo > eb;
  assign c_right = chi < ee;
  assign a_lo    = (eb + GUARD34 + {2'b00, ralign} - 34'd1) & ~({2'b00, ralign} - 34'd1);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: state_next = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          if (in_act == ACT_REINIT || in_size == 32'd0 || (in_act == ACT_FREE && in_bad)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if ((act != ACT_FREE && hit) || (!issue && !rd_vld)) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (act == ACT_FREE) begin
          priority if (hit) begin
            state_next = f_join ? S_SHDN : S_DONE;
          end else if (p_join || full) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SHUP;
          end
        end else begin
          state_next = hit ? S_CARVE : S_DONE;
        end
      end
      S_CARVE: begin
        priority if (c_left && c_right) begin
          state_next = full ? S_DONE : S_SHUP;
        end else if (c_left || c_right) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SHDN;
        end
      end
      S_SHUP: if (sh_n == '0 && !sh_vld) state_next = S_DONE;
      S_SHDN: if (sh_n == '0 && !sh_vld) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ram port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata;
    mem_raddr = scan_ptr[AW-1:0];
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {SPACE_SIZE_RST, SPACE_BASE_RST};
      end
      S_IDLE: begin
        if (acc && in_act == ACT_REINIT && ri_sz != 33'd0) begin
          mem_we    = 1'b1;
          mem_wdata = {ri_sz[31:0], space_base};
        end
      end
      S_EVAL: begin
        if (act == ACT_FREE) begin
          priority if (hit) begin
            mem_we    = 1'b1;
            mem_waddr = hit_idx;
            mem_wdata = {f_join ? f_sum2[31:0] : f_sum1[31:0], hit_base};
          end else if (p_join) begin
            mem_we    = 1'b1;
            mem_waddr = p_idx;
            mem_wdata = {p_sum[31:0], rbase};
          end else begin
            mem_we = 1'b0;
          end
        end
      end
      S_CARVE: begin
        mem_waddr = hit_idx;
        priority if (c_left && c_right) begin
          mem_we    = !full;
          mem_wdata = {32'(lo - eb), hit_base};
        end else if (c_left) begin
          mem_we    = 1'b1;
          mem_wdata = {32'(lo - eb), hit_base};
        end else if (c_right) begin
          mem_we    = 1'b1;
          mem_wdata = {32'(ee - chi), chi[31:0]};
        end else begin
          mem_we = 1'b0;
        end
      end
      S_SHUP: begin
        mem_raddr = sh_src;
        if (sh_vld) begin
          mem_we    = 1'b1;
          mem_waddr = sh_dst;
        end else if (sh_n == '0) begin
          mem_we    = 1'b1;
          mem_waddr = ins_pos;
          mem_wdata = {ins_size, ins_base};
        end
      end
      S_SHDN: begin
        mem_raddr = sh_src;
        if (sh_vld) begin
          mem_we    = 1'b1;
          mem_waddr = sh_dst;
        end
      end
      default: ;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= CW'(1);
      m_tvalid <= 1'b0;
      rd_vld   <= 1'b0;
      sh_vld   <= 1'b0;
    end else begin
      // output register loads from the done state, else drains on acceptance
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: count <= CW'(1);
        S_IDLE: begin
          scan_ptr <= '0;
          rd_vld   <= 1'b0;
          hit      <= 1'b0;
          nxt_hit  <= 1'b0;
          p_hit    <= 1'b0;
          if (acc) begin
            act        <= in_act;
            rbase      <= in_base;
            rsize      <= in_size;
            ralign     <= top_bit(s_tdata[97:66]);
            need       <= {2'b00, in_size} + GUARD2 + {2'b00, top_bit(s_tdata[97:66])};
            rhi        <= in_hi;
            res_base   <= '0;
            res_size   <= '0;
            priority if (in_act == ACT_REINIT) begin
              count      <= (ri_sz != 33'd0) ? CW'(1) : '0;
              res_status <= ST_OK;
            end else if (in_size == 32'd0) begin
              res_status <= ST_ZERO;
            end else if (in_act == ACT_FREE && in_bad) begin
              res_status <= ST_BADFREE;
            end else begin
              res_status <= ST_OK;
            end
          end
        end
        S_SCAN: begin
          rd_vld   <= issue;
          rd_idx   <= scan_ptr[AW-1:0];
          scan_ptr <= scan_ptr + CW'(issue);
          if (rd_vld) begin
            unique case (act)
              ACT_ANYWHERE, ACT_SPECIFIC: begin
                if (!hit && ((act == ACT_ANYWHERE) ? m_any : m_spec)) begin
                  hit      <= 1'b1;
                  hit_idx  <= rd_idx;
                  hit_base <= e_base;
                  hit_size <= e_size;
                end
              end
              default: begin
                if (!hit && m_pred) begin
                  hit      <= 1'b1;
                  hit_idx  <= rd_idx;
                  hit_base <= e_base;
                  hit_size <= e_size;
                end else if (hit && ({1'b0, rd_idx} == {1'b0, hit_idx} + (AW+1)'(1))) begin
                  nxt_hit  <= 1'b1;
                  nxt_base <= e_base;
                  nxt_size <= e_size;
                end
                if (!p_hit && m_p) begin
                  p_hit  <= 1'b1;
                  p_idx  <= rd_idx;
                  p_base <= e_base;
                  p_size <= e_size;
                end
              end
            endcase
          end
        end
        S_EVAL: begin
          sh_vld <= 1'b0;
          if (act == ACT_FREE) begin
            priority if (hit) begin
              // drop the absorbed successor
              sh_src <= AW'(hit_idx + AW'(2));
              sh_n   <= count - CW'(2) - CW'(hit_idx);
            end else if (p_join) begin
              res_status <= ST_OK;
            end else if (full) begin
              res_status <= ST_FULL;
            end else begin
              ins_pos  <= p_hit ? p_idx : count[AW-1:0];
              ins_base <= rbase;
              ins_size <= rsize;
              sh_src   <= AW'(count - CW'(1));
              sh_n     <= count - (p_hit ? CW'(p_idx) : count);
            end
          end else if (!hit) begin
            res_status <= ST_NOFIT;
          end else begin
            lo <= (act == ACT_ANYWHERE) ? a_lo : {2'b00, rbase};
          end
        end
        S_CARVE: begin
          priority if (c_left && c_right) begin
            if (full) begin
              res_status <= ST_FULL;
            end else begin
              ins_pos  <= AW'(hit_idx + AW'(1));
              ins_base <= chi[31:0];
              ins_size <= 32'(ee - chi);
              sh_src   <= AW'(count - CW'(1));
              sh_n     <= count - CW'(1) - CW'(hit_idx);
              res_base <= lo[31:0];
              res_size <= rsize;
            end
          end else if (c_left || c_right) begin
            res_base <= lo[31:0];
            res_size <= rsize;
          end else begin
            sh_src   <= AW'(hit_idx + AW'(1));
            sh_n     <= count - CW'(1) - CW'(hit_idx);
            res_base <= lo[31:0];
            res_size <= rsize;
          end
        end
        S_SHUP: begin
          if (sh_n != '0) begin
            sh_vld <= 1'b1;
            sh_dst <= AW'(sh_src + AW'(1));
            sh_src <= AW'(sh_src - AW'(1));
            sh_n   <= sh_n - CW'(1);
          end else begin
            sh_vld <= 1'b0;
            if (!sh_vld) begin
              count <= count + CW'(1);
            end
          end
        end
        S_SHDN: begin
          if (sh_n != '0) begin
            sh_vld <= 1'b1;
            sh_dst <= AW'(sh_src - AW'(1));
            sh_src <= AW'(sh_src + AW'(1));
            sh_n   <= sh_n - CW'(1);
          end else begin
            sh_vld <= 1'b0;
            if (!sh_vld) begin
              count <= count - CW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata  <= {5'd0, res_status, res_size, res_base};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire
